### design/dvru_pkg.sv
// Shared types, codes and helpers for the distance-vector route update engine.
package dvru_pkg;

   localparam logic [4:0] COST_INF    = 5'd16;
   localparam logic [4:0] COST_DIRECT = 5'd1;

   typedef enum logic [1:0] {
      ACT_UNCHANGED = 2'd0,
      ACT_UPDATED   = 2'd1,
      ACT_INSERTED  = 2'd2,
      ACT_DROPPED   = 2'd3
   } action_type;

   // route word walking the cell row
   typedef struct packed {
      logic        valid;
      logic [31:0] dest;
      logic [4:0]  adv;
      logic [31:0] sender;
      logic [31:0] recv;
      logic        eom;
      logic        found;
      action_type  action;
      logic [4:0]  cost;
      logic [31:0] hop;
      logic [31:0] ifc;
   } token_type;

   // slot write broadcast for an insert
   typedef struct packed {
      logic        en;
      logic [31:0] dest;
      logic [4:0]  cost;
      logic [31:0] hop;
      logic [31:0] ifc;
   } write_type;

   function automatic logic [4:0] sat_cost(input logic [4:0] adv);
      logic [5:0] sum;
      begin
         sum = {1'b0, adv} + 6'd1;
         return (sum > {1'b0, COST_INF}) ? COST_INF : sum[4:0];
      end
   endfunction

endpackage

### design/dvru_cell.sv
// One routing table slot: compares and updates against the passing route word.
module dvru_cell #(
   parameter int Index = 0,
   parameter int IdxW  = 5,
   parameter int CntW  = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  dvru_pkg::token_type in_tok,
   input  logic [IdxW-1:0]     in_idx,
   input  logic [CntW-1:0]     used_count,
   input  dvru_pkg::write_type wr,
   input  logic [IdxW-1:0]     wr_idx,
   output dvru_pkg::token_type out_tok,
   output logic [IdxW-1:0]     out_idx
);

   logic [31:0] dest_ff;
   logic [4:0]  cost_ff;
   logic [31:0] hop_ff;
   logic [31:0] ifc_ff;

   dvru_pkg::token_type tok_ff, tok_in;
   logic [IdxW-1:0]     idx_ff, idx_in;

   logic       live;
   logic       better;
   logic [4:0] new_cost;

   always_comb begin
      new_cost = dvru_pkg::sat_cost(in_tok.adv);
      live     = in_tok.valid && !in_tok.found && (CntW'(Index) < used_count)
                 && (dest_ff == in_tok.dest);
      better   = ({1'b0, cost_ff} > ({1'b0, in_tok.adv} + 6'd1))
                 || (hop_ff == in_tok.sender);
   end

   always_comb begin
      tok_in = in_tok;
      idx_in = in_idx;
      if (live) begin
         tok_in.found = 1'b1;
         tok_in.ifc   = ifc_ff;
         idx_in       = IdxW'(Index);
         if (better) begin
            tok_in.action = dvru_pkg::ACT_UPDATED;
            tok_in.cost   = new_cost;
            tok_in.hop    = in_tok.sender;
         end else begin
            tok_in.action = dvru_pkg::ACT_UNCHANGED;
            tok_in.cost   = cost_ff;
            tok_in.hop    = hop_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx == IdxW'(Index))) begin
         dest_ff <= wr.dest;
         cost_ff <= wr.cost;
         hop_ff  <= wr.hop;
         ifc_ff  <= wr.ifc;
      end else if (live && better) begin
         cost_ff <= new_cost;
         hop_ff  <= in_tok.sender;
      end
   end

   assign out_tok = tok_ff;
   assign out_idx = idx_ff;

endmodule

### design/distance_vector_route_update_core.sv
// Top level of the distance-vector route update engine: cell row, insert and result stage.
//
// Usage: one advertised route is a word on the req_ channel (destination, advertised
// cost, sender, receiving interface; tlast marks the last route of a message). Each
// route produces exactly one word on the rsp_ channel: the action in tuser and the
// slot index, cost, next hop, interface and entry count in tdata; tlast echoes the
// request's tlast.
// The route walks a row of TABLE_ENTRIES slot cells, one cell per cycle; the first
// valid slot holding the destination checks and rewrites itself on the way. At the
// end of the row an unknown destination is written into the next free slot, or
// dropped when the table is full.
// A route is registered at launch, in each cell of the row, in the finish stage and
// in the output register. One route is in flight at a time: a new route is taken only
// once the last one has moved from the finish stage into the output register.
// req_tready is low while a route is in flight. A finished result waits in the
// output register; a stalled rsp_ side holds it and the next route may still enter,
// its result waiting in a finish stage until the output register frees up.
// Reset empties the table (entry count to zero) and drops any word in flight.
module distance_vector_route_update_core #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dest_addr[31:0], adv_cost[36:32], sender_addr[68:37], recv_if_addr[100:69], zero pad
   input  logic [103:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_index[4:0], entry_cost[9:5], entry_next_hop[41:10],
   // entry_interface[73:42], entries_used[79:74]
   output logic [79:0]  rsp_tdata,
   // action[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int IdxW = $clog2(TABLE_ENTRIES);
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);

   dvru_pkg::token_type tok [TABLE_ENTRIES+1];
   logic [IdxW-1:0]     hit_idx [TABLE_ENTRIES+1];

   dvru_pkg::token_type launch_ff, launch_in;
   logic                busy_ff, busy_in;
   logic [CntW-1:0]     used_ff, used_in;

   dvru_pkg::write_type wr;
   logic [IdxW-1:0]     wr_idx;

   logic                 fin_valid_ff, fin_valid_in;
   dvru_pkg::action_type fin_act_ff, fin_act_in;
   logic [IdxW-1:0]      fin_idx_ff, fin_idx_in;
   logic [4:0]           fin_cost_ff, fin_cost_in;
   logic [31:0]          fin_hop_ff, fin_hop_in;
   logic [31:0]          fin_ifc_ff, fin_ifc_in;
   logic [CntW-1:0]      fin_cnt_ff, fin_cnt_in;
   logic                 fin_eom_ff, fin_eom_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                fin_move;
   dvru_pkg::token_type tail;
   logic [IdxW-1:0]     tail_idx;
   logic [IdxW+4:0]     idx_wide;
   logic [CntW+5:0]     cnt_wide;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign fin_move   = fin_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign tail       = tok[TABLE_ENTRIES];
   assign tail_idx   = hit_idx[TABLE_ENTRIES];

   // launch a route into the cell row
   always_comb begin
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      if (accept) begin
         launch_in.valid  = 1'b1;
         launch_in.dest   = req_tdata[31:0];
         launch_in.adv    = req_tdata[36:32];
         launch_in.sender = req_tdata[68:37];
         launch_in.recv   = req_tdata[100:69];
         launch_in.eom    = req_tlast;
         launch_in.found  = 1'b0;
         launch_in.action = dvru_pkg::ACT_DROPPED;
         launch_in.cost   = '0;
         launch_in.hop    = '0;
         launch_in.ifc    = '0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (fin_move) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   assign tok[0]     = launch_ff;
   assign hit_idx[0] = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      dvru_cell #(
         .Index (i),
         .IdxW  (IdxW),
         .CntW  (CntW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_tok     (tok[i]),
         .in_idx     (hit_idx[i]),
         .used_count (used_ff),
         .wr         (wr),
         .wr_idx     (wr_idx),
         .out_tok    (tok[i+1]),
         .out_idx    (hit_idx[i+1])
      );
   end

   // resolve the route at the end of the row: hit, insert or drop
   always_comb begin
      wr           = '0;
      wr_idx       = used_ff[IdxW-1:0];
      used_in      = used_ff;
      fin_valid_in = fin_valid_ff && !fin_move;
      fin_act_in   = fin_act_ff;
      fin_idx_in   = fin_idx_ff;
      fin_cost_in  = fin_cost_ff;
      fin_hop_in   = fin_hop_ff;
      fin_ifc_in   = fin_ifc_ff;
      fin_cnt_in   = fin_cnt_ff;
      fin_eom_in   = fin_eom_ff;
      if (tail.valid) begin
         fin_valid_in = 1'b1;
         fin_eom_in   = tail.eom;
         priority if (tail.found) begin
            fin_act_in  = tail.action;
            fin_idx_in  = tail_idx;
            fin_cost_in = tail.cost;
            fin_hop_in  = tail.hop;
            fin_ifc_in  = tail.ifc;
            fin_cnt_in  = used_ff;
         end else if (used_ff < CntW'(TABLE_ENTRIES)) begin
            wr.en       = 1'b1;
            wr.dest     = tail.dest;
            wr.cost     = (tail.sender == tail.dest) ? dvru_pkg::COST_DIRECT
                                                     : dvru_pkg::sat_cost(tail.adv);
            wr.hop      = tail.sender;
            wr.ifc      = tail.recv;
            used_in     = used_ff + CntW'(1);
            fin_act_in  = dvru_pkg::ACT_INSERTED;
            fin_idx_in  = used_ff[IdxW-1:0];
            fin_cost_in = wr.cost;
            fin_hop_in  = tail.sender;
            fin_ifc_in  = tail.recv;
            fin_cnt_in  = used_in;
         end else begin
            fin_act_in  = dvru_pkg::ACT_DROPPED;
            fin_idx_in  = '0;
            fin_cost_in = '0;
            fin_hop_in  = '0;
            fin_ifc_in  = '0;
            fin_cnt_in  = used_ff;
         end
      end
   end

   // pack the finished word into the output register
   always_comb begin
      idx_wide     = {5'd0, fin_idx_ff};
      cnt_wide     = {6'd0, fin_cnt_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (fin_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cnt_wide[5:0], fin_ifc_ff, fin_hop_ff, fin_cost_ff, idx_wide[4:0]};
         rsp_user_in  = fin_act_ff;
         rsp_last_in  = fin_eom_ff;
      end
   end

   always_ff @(posedge clock) begin
      fin_act_ff  <= fin_act_in;
      fin_idx_ff  <= fin_idx_in;
      fin_cost_ff <= fin_cost_in;
      fin_hop_ff  <= fin_hop_in;
      fin_ifc_ff  <= fin_ifc_in;
      fin_cnt_ff  <= fin_cnt_in;
      fin_eom_ff  <= fin_eom_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         launch_ff    <= '0;
         busy_ff      <= 1'b0;
         used_ff      <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff    <= launch_in;
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### design/dvru_checker.sv
// Port-level checks for the distance-vector route update engine, bound to the top level.
module dvru_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second route taken while one is in flight");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dvru_pkg::ACT_DROPPED)
      |-> (rsp_tdata[4:0] == 5'd0) && (rsp_tdata[9:5] == 5'd0))
      else $error("dropped route reports a slot");

   a_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == dvru_pkg::ACT_INSERTED)
                     || (rsp_tuser == dvru_pkg::ACT_UPDATED))
      |-> (rsp_tdata[9:5] != 5'd0) && (rsp_tdata[9:5] <= dvru_pkg::COST_INF))
      else $error("written cost out of range");

endmodule

bind distance_vector_route_update_core dvru_checker u_dvru_checker (.*);

### test/testbench.sv
// Self-checking testbench for the distance-vector route update core: random and directed routes.
module testbench;

   localparam int TABLE_SLOTS = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ROUTES = 1100;
   localparam int CALM_FROM = 500;
   localparam int CALM_TO = 700;

   typedef struct packed {
      logic [31:0] dest;
      logic [4:0]  adv;
      logic [31:0] sender;
      logic [31:0] recv;
      logic        eom;
   } route_word;

   typedef struct packed {
      dvru_pkg::action_type action;
      logic [4:0]  index;
      logic [4:0]  cost;
      logic [31:0] hop;
      logic [31:0] ifc;
      logic [5:0]  used;
      logic        done;
   } route_outcome;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   route_word    route_q[$];
   route_outcome outcome_q[$];
   route_word    live_route;
   int           routes_sent;
   int           routes_taken;
   int           drill_len;
   int           errors;
   int           idle_cycles;

   logic [31:0]  tbl_dest[TABLE_SLOTS];
   logic [4:0]   tbl_cost[TABLE_SLOTS];
   logic [31:0]  tbl_hop[TABLE_SLOTS];
   logic [31:0]  tbl_ifc[TABLE_SLOTS];
   int           tbl_used;

   distance_vector_route_update_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [4:0] hop_cost(logic [4:0] adv);
      return (adv >= dvru_pkg::COST_INF) ? dvru_pkg::COST_INF : adv + 5'd1;
   endfunction

   function automatic route_outcome route_table_update(route_word w);
      route_outcome o;
      int slot;
      slot = -1;
      o = '0;
      o.action = dvru_pkg::ACT_DROPPED;
      o.done = w.eom;
      for (int i = 0; i < tbl_used; i++) begin
         if (slot < 0 && tbl_dest[i] == w.dest)
            slot = i;
      end
      if (slot >= 0) begin
         if (int'(tbl_cost[slot]) > int'(w.adv) + 1 || tbl_hop[slot] == w.sender) begin
            tbl_cost[slot] = hop_cost(w.adv);
            tbl_hop[slot] = w.sender;
            o.action = dvru_pkg::ACT_UPDATED;
         end else begin
            o.action = dvru_pkg::ACT_UNCHANGED;
         end
         o.index = 5'(slot);
         o.cost = tbl_cost[slot];
         o.hop = tbl_hop[slot];
         o.ifc = tbl_ifc[slot];
      end else if (tbl_used < TABLE_SLOTS) begin
         tbl_dest[tbl_used] = w.dest;
         tbl_ifc[tbl_used] = w.recv;
         tbl_hop[tbl_used] = w.sender;
         tbl_cost[tbl_used] = (w.sender == w.dest) ? dvru_pkg::COST_DIRECT
                                                   : hop_cost(w.adv);
         o.action = dvru_pkg::ACT_INSERTED;
         o.index = 5'(tbl_used);
         o.cost = tbl_cost[tbl_used];
         o.hop = w.sender;
         o.ifc = w.recv;
         tbl_used++;
      end
      o.used = 6'(tbl_used);
      return o;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic queue_route(logic [31:0] dest, logic [4:0] adv, logic [31:0] sender,
                              logic [31:0] recv, logic eom);
      route_word w;
      w.dest = dest;
      w.adv = adv;
      w.sender = sender;
      w.recv = recv;
      w.eom = eom;
      route_q.insert(route_q.size(), w);
   endtask

   // drive at the falling edge
   always @(negedge clock) begin
      logic calm;
      logic present;
      logic drain_hold;
      if (!reset) begin
         calm = routes_sent >= CALM_FROM && routes_sent < CALM_TO;
         present = routes_taken < routes_sent;
         drain_hold = (routes_sent == drill_len || routes_sent == 400 || routes_sent == 900)
                      && outcome_q.size() != 0;
         if (!present && route_q.size() != 0 && !drain_hold
             && (calm || $urandom_range(99) >= 37)) begin
            live_route = route_q.pop_front();
            routes_sent++;
            present = 1'b1;
         end
         req_tvalid <= present;
         req_tdata <= {3'b000, live_route.recv, live_route.sender, live_route.adv,
                       live_route.dest};
         req_tlast <= live_route.eom;
         rsp_tready <= calm || $urandom_range(99) >= 37;
      end
   end

   // sample at the rising edge
   always @(posedge clock) begin
      route_outcome got;
      route_outcome want;
      if (!reset) begin
         idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            got.action = dvru_pkg::action_type'(rsp_tuser);
            got.index = rsp_tdata[4:0];
            got.cost = rsp_tdata[9:5];
            got.hop = rsp_tdata[41:10];
            got.ifc = rsp_tdata[73:42];
            got.used = rsp_tdata[79:74];
            got.done = rsp_tlast;
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
            end else begin
               want = outcome_q.pop_front();
               compare_field("action", want.action, got.action);
               compare_field("entry_index", want.index, got.index);
               compare_field("entry_cost", want.cost, got.cost);
               compare_field("entry_next_hop", want.hop, got.hop);
               compare_field("entry_interface", want.ifc, got.ifc);
               compare_field("entries_used", want.used, got.used);
               compare_field("message_done", want.done, got.done);
            end
         end
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            outcome_q.insert(outcome_q.size(), route_table_update(live_route));
            routes_taken++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] dest_pool[40];
      logic [31:0] neighbours[6];
      logic [31:0] ifaces[3];
      logic [31:0] nb;
      logic [31:0] ifc;
      logic [31:0] dest;
      logic [4:0]  adv;
      int          len;
      int          r;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      live_route = '0;
      routes_sent = 0;
      routes_taken = 0;
      errors = 0;
      idle_cycles = 0;
      tbl_used = 0;

      queue_route(32'h0000_0000, 5'd0, 32'h0A00_0001, 32'h0000_0000, 1'b0);
      queue_route(32'hFFFF_FFFF, 5'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_route(32'hC0A8_0100, 5'd5, 32'h0A00_0001, 32'hC0A8_0001, 1'b0);
      queue_route(32'hC0A8_0100, 5'd7, 32'h0A00_0002, 32'hC0A8_0002, 1'b0);
      queue_route(32'hC0A8_0100, 5'd2, 32'h0A00_0002, 32'hC0A8_0002, 1'b0);
      queue_route(32'hC0A8_0100, 5'd20, 32'h0A00_0002, 32'hC0A8_0002, 1'b1);
      queue_route(32'hC0A8_0100, 5'd31, 32'h0A00_0001, 32'hC0A8_0001, 1'b0);
      queue_route(32'h0A0A_0000, 5'd31, 32'h0A00_0001, 32'hC0A8_0003, 1'b0);
      queue_route(32'h0A0A_0000, 5'd15, 32'h0A00_0002, 32'hC0A8_0002, 1'b0);
      queue_route(32'h0A0A_0000, 5'd14, 32'h0A00_0002, 32'hC0A8_0002, 1'b1);
      queue_route(32'h0000_0000, 5'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_route(32'h0000_0000, 5'd16, 32'h0A00_0001, 32'h0000_0000, 1'b1);
      queue_route(32'h5555_5555, 5'd0, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 1'b1);
      queue_route(32'hAAAA_AAAA, 5'd3, 32'hAAAA_AAAA, 32'hA5A5_A5A5, 1'b0);
      queue_route(32'hAAAA_AAAA, 5'd0, 32'h5555_5555, 32'hA5A5_A5A5, 1'b1);
      drill_len = route_q.size();

      foreach (dest_pool[i]) dest_pool[i] = $urandom;
      foreach (neighbours[i]) neighbours[i] = $urandom;
      foreach (ifaces[i]) ifaces[i] = $urandom;
      while (route_q.size() < drill_len + RANDOM_ROUTES) begin
         if ($urandom_range(99) < 10) begin
            queue_route($urandom, 5'($urandom_range(0, 31)), $urandom, $urandom,
                        1'($urandom_range(0, 1)));
         end else begin
            nb = neighbours[$urandom_range(0, 5)];
            ifc = ifaces[$urandom_range(0, 2)];
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               dest = ($urandom_range(0, 9) == 0) ? nb : dest_pool[$urandom_range(0, 39)];
               r = $urandom_range(99);
               if (r < 6)
                  adv = 5'($urandom_range(17, 31));
               else if (r < 18)
                  adv = dvru_pkg::COST_INF;
               else
                  adv = 5'($urandom_range(0, 15));
               queue_route(dest, adv, nb, ifc, k == len - 1);
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (route_q.size() != 0 || routes_taken != routes_sent || outcome_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

### distance_vector_route_update_core.f
design/dvru_pkg.sv
design/dvru_cell.sv
design/distance_vector_route_update_core.sv
design/dvru_checker.sv
test/testbench.sv
